// File: hw/rtl/tfu_pkg.sv
// Shared types and constants for the texel format unpacker.
`default_nettype none

package tfu_pkg;

    // Source format codes as written to the format register
    typedef enum logic [2:0] {
        FMT_RGBA8888 = 3'd0,
        FMT_RGBA4444 = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_LA88     = 3'd3,
        FMT_L8       = 3'd4
    } t_src_fmt;

    localparam int FMT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int HELD_N  = 3;
    localparam int PHASE_W = 2;
    localparam int NEED_W  = 3;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

    typedef logic [BYTE_W-1:0] t_byte;

    // One expanded RGBA8888 pixel, red in the low byte
    typedef struct packed {
        t_byte alpha;
        t_byte blue;
        t_byte green;
        t_byte red;
    } t_pixel;

    // Bytes per pixel for a format code; zero for codes without a format
    function automatic logic [NEED_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
        logic [NEED_W-1:0] need;
        case (fmt)
            FMT_RGBA8888: need = 3'd4;
            FMT_RGBA4444: need = 3'd2;
            FMT_RGB565:   need = 3'd2;
            FMT_LA88:     need = 3'd2;
            FMT_L8:       need = 3'd1;
            default:      need = 3'd0;
        endcase
        return need;
    endfunction

    // Widen a 4-bit channel to 8 bits (n * 17)
    function automatic t_byte expand_nibble(input logic [3:0] n);
        return {n, n};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/texel_format_unpacker_unit.sv
// Texel format unpacker: byte stream in, RGBA8888 pixel stream out.
//
// Usage:
//   Slave stream carries one texture byte per word (tdata) and a start-of-image
//   flag (tuser); the flag restarts the byte phase at that byte. The master
//   stream carries one RGBA8888 pixel per word. The format register, written
//   through i_cfg_wr_en / i_cfg_wr_data while the block is idle, picks the
//   source format and thus how many bytes build one pixel (4, 2 or 1).
//   Codes without a format swallow bytes and produce nothing.
// Throughput and path:
//   One byte is taken every cycle while s_axis_tready is high. The pixel is
//   registered in the output register, or in the skid register while the
//   output register holds a waiting pixel; the expansion is a single pass of
//   byte selection between the phase/held-byte registers and the output register.
// Reset:
//   Synchronous, active low. Clears the phase, the held bytes, the format
//   (RGBA8888) and both output slots.
// Stall:
//   A two-slot output (output register plus skid register) keeps s_axis_tready
//   high while one pixel waits; tready drops only when both slots hold pixels.
`default_nettype none

module texel_format_unpacker_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // format register write
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [tfu_pkg::FMT_W-1:0] i_cfg_wr_data,
    // byte stream in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
    input  wire logic [0:0]             s_axis_tuser,  // [0] start_of_image
    // pixel stream out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [31:0]                 m_axis_tdata   // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [31:24] alpha
);
    import tfu_pkg::*;

    logic [FMT_W-1:0]   r_src_fmt;
    t_byte              r_held [HELD_N];
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    t_pixel             r_out;
    logic               r_out_valid;
    t_pixel             r_skid;
    logic               r_skid_valid;

    logic               in_fire;
    logic               out_fire;
    logic [PHASE_W-1:0] cur_phase;
    logic [NEED_W-1:0]  need;
    logic               pix_done;
    logic               hold_byte;
    t_byte              data;
    t_pixel             pix;
    logic [15:0]        p16;

    assign data          = s_axis_tdata;
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Work out where this byte lands in the current pixel
    always_comb begin
        cur_phase = s_axis_tuser[0] ? '0 : r_phase;
        need      = bytes_per_pixel(r_src_fmt);
        hold_byte = (need != '0) && (({1'b0, cur_phase} + 3'd1) < need);
        pix_done  = (need != '0) && !hold_byte;
        if (hold_byte) begin
            n_phase = cur_phase + 2'd1;
        end else begin
            n_phase = '0;
        end
    end

    // Expand the completed pixel; the last byte is always the current one
    always_comb begin
        p16 = {data, r_held[0]};
        case (r_src_fmt)
            FMT_RGBA8888: begin
                pix = '{alpha: data, blue: r_held[2], green: r_held[1], red: r_held[0]};
            end
            FMT_RGBA4444: begin
                pix = '{alpha: expand_nibble(p16[3:0]),   blue: expand_nibble(p16[7:4]),
                        green: expand_nibble(p16[11:8]), red: expand_nibble(p16[15:12])};
            end
            FMT_RGB565: begin
                pix = '{alpha: ALPHA_OPAQUE, blue: {p16[4:0], 3'b000},
                        green: {p16[10:5], 2'b00}, red: {p16[15:11], 3'b000}};
            end
            FMT_LA88: begin
                pix = '{alpha: data, blue: r_held[0], green: r_held[0], red: r_held[0]};
            end
            default: begin
                pix = '{alpha: data, blue: data, green: data, red: data};
            end
        endcase
    end

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_RGBA8888;
        end else if (i_cfg_wr_en) begin
            r_src_fmt <= i_cfg_wr_data;
        end
    end

    // Byte phase and held bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            for (int k = 0; k < HELD_N; k++) begin
                r_held[k] <= '0;
            end
        end else if (in_fire) begin
            r_phase <= n_phase;
            if (hold_byte) begin
                case (cur_phase)
                    2'd0:    r_held[0] <= data;
                    2'd1:    r_held[1] <= data;
                    2'd2:    r_held[2] <= data;
                    default: r_held[0] <= r_held[0];
                endcase
            end
        end
    end

    // Output slot and skid slot: refill from skid first, else take the new pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire && pix_done) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= pix;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= pix;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tfu_checker.sv
// Port-level checks for the texel format unpacker, bound to the top level.
`default_nettype none

module tfu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A pixel only shows up after a byte was taken
    a_valid_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("pixel appeared without an accepted byte");

    // Back-pressure on the input only when a pixel is waiting
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // Both slots stay full while the receiver stalls
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && !m_axis_tready |=> !s_axis_tready)
        else $error("skid slot lost while receiver stalled");

    // A stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled pixel changed");

endmodule

bind texel_format_unpacker_unit tfu_checker u_tfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/texel_format_unpacker_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the texel format unpacker: tracks the format, predicts pixels, compares them.
module texel_format_unpacker_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [tfu_pkg::FMT_W-1:0]  i_cfg_wr_data,
    input  wire logic                       i_s_tvalid,
    input  wire logic                       i_s_tready,
    input  wire logic [7:0]                 i_s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]                 i_s_tuser,   // [0] start_of_image
    input  wire logic                       i_m_tvalid,
    input  wire logic                       i_m_tready,
    input  wire logic [31:0]                i_m_tdata,   // [7:0] red, [15:8] green,
                                                         // [23:16] blue, [31:24] alpha
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_pixel_count
);
    import tfu_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [FMT_W-1:0] src_fmt;
    logic [23:0]      held;
    int unsigned      phase;
    t_pixel           pixels_due[$];
    int               fail_count;
    int               pixel_count;

    assign o_fail_count  = fail_count;
    assign o_pixel_count = pixel_count;

    initial begin
        fail_count  = 0;
        pixel_count = 0;
        o_pending   = 0;
    end

    // Bytes that make up one pixel in a given format; zero where no format exists
    function automatic int unsigned pixel_bytes(input logic [FMT_W-1:0] fmt);
        case (fmt)
            FMT_RGBA8888: return 4;
            FMT_RGBA4444: return 2;
            FMT_RGB565:   return 2;
            FMT_LA88:     return 2;
            FMT_L8:       return 1;
            default:      return 0;
        endcase
    endfunction

    // Absorb one accepted byte; queue the expanded pixel when it completes one
    task automatic take_byte(input t_byte data, input logic sof);
        int unsigned need;
        logic [31:0] word;
        logic [15:0] p;
        t_pixel      px;
        need = pixel_bytes(src_fmt);
        if (sof)
            phase = 0;
        if (need == 0) begin
            phase = 0;
            return;
        end
        if (phase + 1 < need) begin
            held[phase*8 +: 8] = data;
            phase = phase + 1;
            return;
        end
        // Earlier bytes come from the held register, the last one is this byte
        word = '0;
        for (int k = 0; k + 1 < need; k++)
            word[k*8 +: 8] = held[k*8 +: 8];
        word[(need-1)*8 +: 8] = data;
        phase = 0;
        p = word[15:0];
        case (src_fmt)
            FMT_RGBA8888: begin
                px.red   = word[7:0];
                px.green = word[15:8];
                px.blue  = word[23:16];
                px.alpha = word[31:24];
            end
            FMT_RGBA4444: begin
                px.red   = 8'(p[15:12] * 17);
                px.green = 8'(p[11:8] * 17);
                px.blue  = 8'(p[7:4] * 17);
                px.alpha = 8'(p[3:0] * 17);
            end
            FMT_RGB565: begin
                px.red   = {p[15:11], 3'b000};
                px.green = {p[10:5], 2'b00};
                px.blue  = {p[4:0], 3'b000};
                px.alpha = ALPHA_OPAQUE;
            end
            FMT_LA88: begin
                px.red   = word[7:0];
                px.green = word[7:0];
                px.blue  = word[7:0];
                px.alpha = word[15:8];
            end
            default: begin
                px.red   = word[7:0];
                px.green = word[7:0];
                px.blue  = word[7:0];
                px.alpha = word[7:0];
            end
        endcase
        pixels_due.push_back(px);
    endtask

    // Compare one delivered pixel against the oldest prediction
    task automatic check_pixel(input t_pixel got);
        t_pixel want;
        pixel_count++;
        if (pixels_due.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: unexpected pixel r=%h g=%h b=%h a=%h",
                         $realtime, got.red, got.green, got.blue, got.alpha);
            return;
        end
        want = pixels_due.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display({"%0t: pixel mismatch, expected r=%h g=%h b=%h a=%h,",
                          " got r=%h g=%h b=%h a=%h"},
                         $realtime, want.red, want.green, want.blue, want.alpha,
                         got.red, got.green, got.blue, got.alpha);
        end
    endtask

    // Follow both channels and the format register at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_fmt = FMT_RGBA8888;
            held    = '0;
            phase   = 0;
            pixels_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_pixel(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                take_byte(i_s_tdata, i_s_tuser[0]);
            if (i_cfg_wr_en)
                src_fmt = i_cfg_wr_data;
        end
        o_pending = pixels_due.size();
    end

endmodule

// File: tb/sv/texel_format_unpacker_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the texel format unpacker: clock, reset, byte stimulus, verdict.
module texel_format_unpacker_unit_tb;
    import tfu_pkg::*;

    // Register codes that select no format
    localparam logic [FMT_W-1:0] FMT_NONE_FIRST = 3'd5;
    localparam logic [FMT_W-1:0] FMT_NONE_LAST  = 3'd7;
    localparam int RANDOM_BYTES = 1900;
    localparam int CALM_TAIL    = 300;
    localparam int SETTLE_CYC   = 3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [FMT_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;

    int fail_count;
    int pending;
    int pixel_count;
    bit gaps_on = 1'b1;
    int ready_hold = 0;
    int bytes_sent = 0;
    int fmt_writes = 0;

    texel_format_unpacker_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    texel_format_unpacker_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixel_count (pixel_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pixel side backpressure: random stall bursts while gaps are enabled
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready = 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(1, 13) - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Offer one byte, possibly after an idle burst, and hold it until accepted
    task automatic push_byte(input t_byte data, input logic sof);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = sof;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        bytes_sent++;
        @(negedge clk);
    endtask

    // Write the format register once the block has drained
    task automatic write_format(input logic [FMT_W-1:0] fmt);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = fmt;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        fmt_writes++;
    endtask

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [FMT_W-1:0] fmt;
        int               len;
        logic             sof;
        t_byte            data;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: one or two pixels per format with extreme channel values
        write_format(FMT_RGBA8888);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h5a, 1'b0);
        push_byte(8'ha5, 1'b0);
        write_format(FMT_RGBA4444);
        push_byte(8'hf0, 1'b1);
        push_byte(8'h0f, 1'b0);
        write_format(FMT_RGB565);
        push_byte(8'hff, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'he0, 1'b0);
        push_byte(8'h07, 1'b0);
        write_format(FMT_LA88);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7f, 1'b0);
        write_format(FMT_L8);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        // Codes without a format swallow bytes
        write_format(FMT_NONE_FIRST);
        push_byte(8'hc3, 1'b1);
        push_byte(8'h3c, 1'b0);
        write_format(FMT_NONE_LAST);
        push_byte(8'h99, 1'b0);
        // Switch format in the middle of a pixel
        write_format(FMT_RGBA8888);
        push_byte(8'h11, 1'b1);
        push_byte(8'h22, 1'b0);
        write_format(FMT_LA88);
        push_byte(8'h33, 1'b0);
        // Start flag in the middle of a pixel restarts it
        write_format(FMT_RGBA8888);
        push_byte(8'haa, 1'b0);
        push_byte(8'hbb, 1'b1);
        push_byte(8'hcc, 1'b0);
        push_byte(8'hdd, 1'b0);
        push_byte(8'hee, 1'b0);

        // Random: runs of bytes under random formats, calm toward the end
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 8)
                fmt = FMT_W'($urandom_range(FMT_RGBA8888, FMT_L8));
            else
                fmt = FMT_W'($urandom_range(FMT_NONE_FIRST, FMT_NONE_LAST));
            write_format(fmt);
            gaps_on = !(bytes_sent >= RANDOM_BYTES - CALM_TAIL || $urandom_range(0, 3) == 0);
            len = $urandom_range(20, 120);
            for (int i = 0; i < len; i++) begin
                sof = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0);
                case ($urandom_range(0, 9))
                    0:       data = 8'h00;
                    1:       data = 8'hff;
                    default: data = 8'($urandom_range(0, 255));
                endcase
                push_byte(data, sof);
            end
        end

        // Drain
        s_tvalid = 1'b0;
        gaps_on  = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Streamed %0d texture bytes under %0d format register writes,",
                 bytes_sent, fmt_writes);
        $display("all formats, dead codes, start flags, mid-pixel switches; %0d pixels compared.",
                 pixel_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
